FILE: rtl/lla_pkg.sv
// Shared types, constants and helper functions for the least-loaded core allocator.
`default_nettype none

package lla_pkg;

  // Sizing of the core table.
  localparam int NUM_CORES    = 16;
  localparam int NUM_SOCKETS  = 4;
  localparam int MAPPED_CORES = 16;
  localparam int SCAN_CORES   = (NUM_CORES < MAPPED_CORES) ? NUM_CORES : MAPPED_CORES;
  localparam int IDX_W        = $clog2(SCAN_CORES);

  // Load counter values.
  localparam logic [7:0] RESERVE_LOAD = 8'(255);
  localparam logic [7:0] FULL_LOAD    = RESERVE_LOAD - 8'd1;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_ACQ_WORKER  = 3'd0,
    OP_ACQ_IO      = 3'd1,
    OP_REL_WORKER  = 3'd2,
    OP_REL_IO      = 3'd3,
    OP_PRESERVE_IO = 3'd4,
    OP_PRESERVE_WK = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ENABLED_MASK = 2'd0,
    REG_SOCKET_MAP   = 2'd1,
    REG_MASTER_CORE  = 2'd2,
    REG_SKIP_MASTER  = 2'd3
  } reg_idx_t;

  // Write request to the load counter bank.
  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic             we_worker;
    logic [7:0]       worker_data;
    logic             we_io;
    logic [7:0]       io_data;
  } lla_wr_t;

  // A core is usable when it exists, is online and is not an excluded master.
  function automatic logic core_usable(input logic [3:0] c, input logic [15:0] en_mask,
                                       input logic skip, input logic [3:0] master);
    logic ok;
    ok = ({1'b0, c} < 5'(SCAN_CORES)) && en_mask[c] && !(skip && (c == master));
    return ok;
  endfunction

  // Socket number of a core from the packed socket map.
  function automatic logic [1:0] core_socket(input logic [3:0] c, input logic [31:0] smap);
    logic [1:0] s;
    s = smap[{c, 1'b0} +: 2];
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lla_load_bank.sv
// Worker and io load counters of every core, one read and one write address.
`default_nettype none

module lla_load_bank (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lla_pkg::IDX_W-1:0]   rd_addr,
  input  wire lla_pkg::lla_wr_t            wr,
  output logic [7:0]                       worker_rd,
  output logic [7:0]                       io_rd
);

  logic [7:0] worker_load [lla_pkg::SCAN_CORES];
  logic [7:0] io_load     [lla_pkg::SCAN_CORES];

  // Every counter starts at the reserve value, so no core is available.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lla_pkg::SCAN_CORES; i++) begin
        worker_load[i] <= lla_pkg::RESERVE_LOAD;
        io_load[i]     <= lla_pkg::RESERVE_LOAD;
      end
    end else begin
      if (wr.we_worker) begin
        worker_load[wr.addr] <= wr.worker_data;
      end
      if (wr.we_io) begin
        io_load[wr.addr] <= wr.io_data;
      end
    end
  end

  // Both counters of the addressed core are read together.
  assign worker_rd = worker_load[rd_addr];
  assign io_rd     = io_load[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/lla_cmp_unit.sv
// Shared compare unit that tracks the least loaded eligible core during a scan.
`default_nettype none

module lla_cmp_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        step,
  input  wire logic                        eligible,
  input  wire logic [lla_pkg::IDX_W-1:0]   idx,
  input  wire logic [7:0]                  val,
  output logic                             found,
  output logic [lla_pkg::IDX_W-1:0]        best_idx,
  output logic [7:0]                       best_val
);

  logic take;

  // A strictly lower load wins, so ties stay with the lower index.
  assign take = step && eligible && (!found || (val < best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  // The best candidate so far.
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= idx;
      best_val <= val;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/least_loaded_core_allocator.sv
// Top level: configuration registers, operation sequencer and result register.
// An acquire goes from the accepting idle state through a scan of all cores with the
// shared comparator to an update step; a release or preserve goes to an execute step.
// A new item is taken only in the idle state; a waiting result holds the final step.
// Synchronous reset clears the configuration registers, rsp_valid and the scan index,
// returns the sequencer to idle and sets every load counter to the reserve value.
`default_nettype none

module least_loaded_core_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Request channel
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [2:0]  op,
  input  wire logic [3:0]  core_index,
  input  wire logic [1:0]  socket_sel,
  input  wire logic        any_socket,
  // Response channel
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [1:0]       status,
  output logic [3:0]       chosen_core,
  output logic [7:0]       load_after
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_EXEC
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] enabled_mask;
  logic [31:0] socket_map;
  logic [3:0]  master_core;
  logic        skip_master;

  // Latched request
  logic [2:0]  op_q;
  logic [3:0]  idx_q;
  logic [1:0]  sel_q;
  logic        any_q;

  logic [lla_pkg::IDX_W-1:0] scan_idx;
  logic [lla_pkg::IDX_W-1:0] rd_addr;
  logic [lla_pkg::IDX_W-1:0] best_idx;
  logic [7:0]                worker_rd;
  logic [7:0]                io_rd;
  logic [7:0]                cur_val;
  logic [7:0]                best_val;
  logic                      kind_io;
  logic                      found;
  logic                      eligible;
  logic                      slot_free;
  logic                      rsp_fire;
  logic                      cmp_clear;
  logic                      cmp_step;
  logic [3:0]                scan_core;
  lla_pkg::lla_wr_t          wr;
  logic [1:0]                res_status;
  logic [3:0]                res_core;
  logic [7:0]                res_load;

  // Register writes complete on the access cycle.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask <= '0;
      socket_map   <= '0;
      master_core  <= '0;
      skip_master  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        lla_pkg::REG_ENABLED_MASK: enabled_mask <= pwdata[15:0];
        lla_pkg::REG_SOCKET_MAP:   socket_map   <= pwdata;
        lla_pkg::REG_MASTER_CORE:  master_core  <= pwdata[3:0];
        lla_pkg::REG_SKIP_MASTER:  skip_master  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      lla_pkg::REG_ENABLED_MASK: prdata = {16'd0, enabled_mask};
      lla_pkg::REG_SOCKET_MAP:   prdata = socket_map;
      lla_pkg::REG_MASTER_CORE:  prdata = {28'd0, master_core};
      lla_pkg::REG_SKIP_MASTER:  prdata = {31'd0, skip_master};
      default:                   prdata = '0;
    endcase
  end

  lla_load_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .wr        (wr),
    .worker_rd (worker_rd),
    .io_rd     (io_rd)
  );

  lla_cmp_unit u_cmp (
    .clk      (clk),
    .rst      (rst),
    .clear    (cmp_clear),
    .step     (cmp_step),
    .eligible (eligible),
    .idx      (scan_idx),
    .val      (cur_val),
    .found    (found),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  // Counter selection and scan eligibility.
  assign kind_io   = (op_q == lla_pkg::OP_ACQ_IO) || (op_q == lla_pkg::OP_REL_IO);
  assign rd_addr   = (state == S_SCAN) ? scan_idx : lla_pkg::IDX_W'(idx_q);
  assign cur_val   = kind_io ? io_rd : worker_rd;
  assign scan_core = 4'(scan_idx);
  assign eligible  = lla_pkg::core_usable(scan_core, enabled_mask, skip_master, master_core)
                     && (cur_val < lla_pkg::FULL_LOAD)
                     && (any_q || (lla_pkg::core_socket(scan_core, socket_map) == sel_q));
  assign cmp_step  = (state == S_SCAN);
  assign cmp_clear = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_fire  = ((state == S_PICK) || (state == S_EXEC)) && slot_free;
  assign req_ready = (state == S_IDLE);

  // Result and counter update of the final step.
  always_comb begin
    wr             = '0;
    wr.addr        = lla_pkg::IDX_W'(idx_q);
    wr.worker_data = cur_val;
    wr.io_data     = cur_val;
    res_status     = lla_pkg::ST_INVALID;
    res_core       = '0;
    res_load       = '0;
    if (state == S_PICK) begin
      if (found) begin
        wr.addr        = best_idx;
        wr.worker_data = best_val + 8'd1;
        wr.io_data     = best_val + 8'd1;
        wr.we_io       = slot_free && kind_io;
        wr.we_worker   = slot_free && !kind_io;
        res_status     = lla_pkg::ST_OK;
        res_core       = 4'(best_idx);
        res_load       = best_val + 8'd1;
      end else begin
        res_status     = lla_pkg::ST_NONE;
      end
    end else if (state == S_EXEC &&
                 lla_pkg::core_usable(idx_q, enabled_mask, skip_master, master_core)) begin
      case (op_q)
        lla_pkg::OP_REL_WORKER, lla_pkg::OP_REL_IO: begin
          if (cur_val == 8'd0 || cur_val == lla_pkg::RESERVE_LOAD) begin
            res_status = lla_pkg::ST_UNDERFLOW;
            res_load   = cur_val;
          end else begin
            wr.worker_data = cur_val - 8'd1;
            wr.io_data     = cur_val - 8'd1;
            wr.we_io       = slot_free && kind_io;
            wr.we_worker   = slot_free && !kind_io;
            res_status     = lla_pkg::ST_OK;
            res_core       = idx_q;
            res_load       = cur_val - 8'd1;
          end
        end
        lla_pkg::OP_PRESERVE_IO: begin
          wr.io_data     = 8'd0;
          wr.worker_data = lla_pkg::RESERVE_LOAD;
          wr.we_io       = slot_free;
          wr.we_worker   = slot_free;
          res_status     = lla_pkg::ST_OK;
          res_core       = idx_q;
        end
        lla_pkg::OP_PRESERVE_WK: begin
          wr.io_data     = lla_pkg::RESERVE_LOAD;
          wr.worker_data = 8'd0;
          wr.we_io       = slot_free;
          wr.we_worker   = slot_free;
          res_status     = lla_pkg::ST_OK;
          res_core       = idx_q;
        end
        default: ;
      endcase
    end
  end

  // Sequencer, latched request and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if (rsp_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q     <= op;
            idx_q    <= core_index;
            sel_q    <= socket_sel;
            any_q    <= any_socket;
            scan_idx <= '0;
            if (op == lla_pkg::OP_ACQ_WORKER || op == lla_pkg::OP_ACQ_IO) begin
              state <= S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == lla_pkg::IDX_W'(lla_pkg::SCAN_CORES - 1)) begin
            state <= S_PICK;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_PICK, S_EXEC: begin
          if (slot_free) begin
            status      <= res_status;
            chosen_core <= res_core;
            load_after  <= res_load;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the least-loaded core allocator.
module tb_top;

  // Opcodes that the block must reject without touching any counter.
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    lla_pkg::status_t status;
    logic [3:0]       core;
    logic [7:0]       load;
  } alloc_outcome_t;

  // Predicts each response from its own copy of the registers and load counters,
  // and checks the responses in order against the predictions.
  class alloc_tracker;
    logic [15:0]    enabled_mask;
    logic [31:0]    socket_map;
    logic [3:0]     master_core;
    logic           skip_master;
    logic [7:0]     worker_load [16];
    logic [7:0]     io_load [16];
    alloc_outcome_t pending_outcomes [$];
    int             mismatches;
    int             responses;
    int             tally [4];

    function new();
      enabled_mask = '0;
      socket_map   = '0;
      master_core  = '0;
      skip_master  = 1'b0;
      mismatches   = 0;
      responses    = 0;
      for (int i = 0; i < 16; i++) begin
        worker_load[i] = lla_pkg::RESERVE_LOAD;
        io_load[i]     = lla_pkg::RESERVE_LOAD;
      end
      for (int i = 0; i < 4; i++) tally[i] = 0;
    endfunction

    function void write_reg(lla_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        lla_pkg::REG_ENABLED_MASK: enabled_mask = v[15:0];
        lla_pkg::REG_SOCKET_MAP:   socket_map   = v;
        lla_pkg::REG_MASTER_CORE:  master_core  = v[3:0];
        lla_pkg::REG_SKIP_MASTER:  skip_master  = v[0];
        default: ;
      endcase
    endfunction

    // A core takes part only when it is online and not the excluded master.
    function bit core_online(logic [3:0] c);
      return enabled_mask[c] && !(skip_master && c == master_core);
    endfunction

    function alloc_outcome_t predict_allocation(logic [2:0] op_v, logic [3:0] idx,
                                                logic [1:0] sel, logic any);
      alloc_outcome_t res;
      bit             found;
      logic [3:0]     best;
      logic [7:0]     best_load;
      logic [7:0]     cur;
      res       = '{lla_pkg::ST_INVALID, 4'd0, 8'd0};
      found     = 1'b0;
      best      = '0;
      best_load = '0;
      if (op_v == lla_pkg::OP_ACQ_WORKER || op_v == lla_pkg::OP_ACQ_IO) begin
        // Scan for the lowest load; the first core found wins a tie.
        for (int c = 0; c < 16; c++) begin
          cur = (op_v == lla_pkg::OP_ACQ_IO) ? io_load[c] : worker_load[c];
          if (core_online(4'(c)) && cur < lla_pkg::FULL_LOAD &&
              (any || socket_map[2*c +: 2] == sel) && (!found || cur < best_load)) begin
            found     = 1'b1;
            best      = 4'(c);
            best_load = cur;
          end
        end
        if (!found) begin
          res = '{lla_pkg::ST_NONE, 4'd0, 8'd0};
        end else begin
          best_load = best_load + 8'd1;
          if (op_v == lla_pkg::OP_ACQ_IO) io_load[best] = best_load;
          else worker_load[best] = best_load;
          res = '{lla_pkg::ST_OK, best, best_load};
        end
      end else if (op_v == OP_UNUSED_A || op_v == OP_UNUSED_B || !core_online(idx)) begin
        res = '{lla_pkg::ST_INVALID, 4'd0, 8'd0};
      end else if (op_v == lla_pkg::OP_REL_WORKER || op_v == lla_pkg::OP_REL_IO) begin
        // A release never goes below zero and never touches a reserved counter.
        cur = (op_v == lla_pkg::OP_REL_IO) ? io_load[idx] : worker_load[idx];
        if (cur == 8'd0 || cur == lla_pkg::RESERVE_LOAD) begin
          res = '{lla_pkg::ST_UNDERFLOW, 4'd0, cur};
        end else begin
          cur = cur - 8'd1;
          if (op_v == lla_pkg::OP_REL_IO) io_load[idx] = cur;
          else worker_load[idx] = cur;
          res = '{lla_pkg::ST_OK, idx, cur};
        end
      end else begin
        // Dedicate the core to one kind and reserve it for the other.
        io_load[idx]     = (op_v == lla_pkg::OP_PRESERVE_IO) ? 8'd0 : lla_pkg::RESERVE_LOAD;
        worker_load[idx] = (op_v == lla_pkg::OP_PRESERVE_IO) ? lla_pkg::RESERVE_LOAD : 8'd0;
        res = '{lla_pkg::ST_OK, idx, 8'd0};
      end
      return res;
    endfunction

    function void note_request(logic [2:0] op_v, logic [3:0] idx, logic [1:0] sel,
                               logic any);
      alloc_outcome_t o;
      o = predict_allocation(op_v, idx, sel, any);
      pending_outcomes.push_back(o);
      tally[o.status]++;
    endfunction

    function void check_response(logic [1:0] st, logic [3:0] core, logic [7:0] load);
      alloc_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("response transfer with no request outstanding: status=%0d core=%0d load=%0d",
               st, core, load);
        mismatches++;
        return;
      end
      o = pending_outcomes.pop_front();
      responses++;
      if (st !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, st);
        mismatches++;
      end
      if (core !== o.core) begin
        $error("chosen_core: expected %0d, got %0d", o.core, core);
        mismatches++;
      end
      if (load !== o.load) begin
        $error("load_after: expected %0d, got %0d", o.load, load);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  op;
  logic [3:0]  core_index;
  logic [1:0]  socket_sel;
  logic        any_socket;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [1:0]  status;
  logic [3:0]  chosen_core;
  logic [7:0]  load_after;

  alloc_tracker sb;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_request;
  int           cycle_count;

  least_loaded_core_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .op         (op),
    .core_index (core_index),
    .socket_sel (socket_sel),
    .any_socket (any_socket),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .chosen_core(chosen_core),
    .load_after (load_after)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response side: check every transfer, stall at random, and hold off on request.
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_response(status, chosen_core, load_after);
      if (hold_request) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write: setup cycle, access cycle, then a cycle with the port released.
  task automatic write_reg(input lla_pkg::reg_idx_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, v);
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] mask, input logic [31:0] smap,
                           input logic [3:0] master, input logic skip);
    write_reg(lla_pkg::REG_ENABLED_MASK, {16'd0, mask});
    write_reg(lla_pkg::REG_SOCKET_MAP, smap);
    write_reg(lla_pkg::REG_MASTER_CORE, {28'd0, master});
    write_reg(lla_pkg::REG_SKIP_MASTER, {31'd0, skip});
  endtask

  // Wait until every outstanding request has been answered and the block is idle.
  task automatic quiesce();
    req_valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one request and hold it until the transfer.
  task automatic send_item(input logic [2:0] op_v, input logic [3:0] idx,
                           input logic [1:0] sel, input logic any);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    op         <= op_v;
    core_index <= idx;
    socket_sel <= sel;
    any_socket <= any;
    do @(posedge clk); while (!req_ready);
    sb.note_request(op_v, idx, sel, any);
  endtask

  // Random mix; releases mostly target cores that currently carry load.
  task automatic send_random(input int count);
    int         r;
    logic [2:0] op_v;
    logic [3:0] idx;
    logic [1:0] sel;
    logic       any;
    logic [7:0] cur;
    logic [3:0] loaded [$];
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      sel = 2'($urandom_range(3));
      any = 1'($urandom_range(1));
      idx = 4'($urandom_range(15));
      if (r < 45) begin
        op_v = $urandom_range(1) ? lla_pkg::OP_ACQ_IO : lla_pkg::OP_ACQ_WORKER;
      end else if (r < 70) begin
        op_v = $urandom_range(1) ? lla_pkg::OP_REL_IO : lla_pkg::OP_REL_WORKER;
        loaded.delete();
        for (int k = 0; k < 16; k++) begin
          cur = (op_v == lla_pkg::OP_REL_IO) ? sb.io_load[k] : sb.worker_load[k];
          if (cur != 8'd0 && cur != lla_pkg::RESERVE_LOAD) loaded.push_back(4'(k));
        end
        if (loaded.size() > 0 && $urandom_range(9) < 7)
          idx = loaded[$urandom_range(loaded.size() - 1)];
      end else if (r < 85) begin
        op_v = $urandom_range(1) ? lla_pkg::OP_PRESERVE_IO : lla_pkg::OP_PRESERVE_WK;
      end else if (r < 90) begin
        op_v = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      end else begin
        op_v = 3'($urandom_range(7));
      end
      send_item(op_v, idx, sel, any);
    end
  endtask

  // Main sequence.
  initial begin
    sb            = new();
    cycle_count   = 0;
    hold_request  = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 66;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    req_valid  <= 1'b0;
    op         <= '0;
    core_index <= '0;
    socket_sel <= '0;
    any_socket <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset every core is offline and every counter is reserved.
    send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'd0, 1'b1);
    send_item(lla_pkg::OP_REL_WORKER, 4'd3, 2'd0, 1'b0);
    quiesce();
    configure(16'hFFFF, 32'hE4E4_E4E4, 4'd0, 1'b0);

    // Reserved counters, unused opcodes, then preserve and acquire with ties.
    send_item(lla_pkg::OP_REL_IO, 4'd5, 2'd0, 1'b0);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd0, 1'b1);
    send_item(OP_UNUSED_A, 4'd1, 2'd1, 1'b0);
    send_item(OP_UNUSED_B, 4'd15, 2'd3, 1'b1);
    send_item(lla_pkg::OP_PRESERVE_WK, 4'd0, 2'd0, 1'b0);
    send_item(lla_pkg::OP_PRESERVE_WK, 4'd15, 2'd0, 1'b0);
    send_item(lla_pkg::OP_PRESERVE_IO, 4'd7, 2'd0, 1'b0);
    send_item(lla_pkg::OP_PRESERVE_IO, 4'd15, 2'd0, 1'b0);
    send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'd2, 1'b1);
    send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'd0, 1'b0);
    send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'd1, 1'b0);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd3, 1'b0);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd3, 1'b0);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd3, 1'b0);

    // Release down to zero, then one release too many.
    send_item(lla_pkg::OP_REL_WORKER, 4'd0, 2'd0, 1'b0);
    send_item(lla_pkg::OP_REL_WORKER, 4'd0, 2'd0, 1'b0);
    send_item(lla_pkg::OP_REL_WORKER, 4'd0, 2'd0, 1'b0);
    quiesce();

    // The excluded master core is invalid for a release or preserve and is skipped by an acquire.
    configure(16'hFFFF, 32'hE4E4_E4E4, 4'd15, 1'b1);
    send_item(lla_pkg::OP_REL_IO, 4'd15, 2'd0, 1'b0);
    send_item(lla_pkg::OP_PRESERVE_IO, 4'd15, 2'd0, 1'b0);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd0, 1'b1);
    quiesce();

    // Random traffic, all cores online, master included.
    configure(16'hFFFF, $urandom(), 4'($urandom_range(15)), 1'b0);
    send_random(380);
    quiesce();

    // Random traffic with holes in the enable mask and the master excluded.
    send_idle_pct = 66;
    recv_idle_pct = 23;
    configure(16'($urandom()) | 16'h0001, $urandom(), 4'($urandom_range(15)), 1'b1);
    send_random(380);
    quiesce();

    // One online core driven to a full counter while the response side holds off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'h8000, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_item(lla_pkg::OP_PRESERVE_WK, 4'd15, 2'd0, 1'b0);
    hold_request = 1'b1;
    repeat (258) send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'($urandom_range(3)), 1'b1);
    send_item(lla_pkg::OP_ACQ_IO, 4'd0, 2'd3, 1'b1);
    send_item(lla_pkg::OP_REL_WORKER, 4'd15, 2'd0, 1'b0);
    send_item(lla_pkg::OP_ACQ_WORKER, 4'd0, 2'd3, 1'b0);
    quiesce();

    // Every core offline, then all online on socket zero with the top core excluded.
    configure(16'h0000, 32'h0000_0000, 4'd15, 1'b1);
    send_random(30);
    quiesce();
    configure(16'hFFFF, 32'h0000_0000, 4'd15, 1'b1);
    send_random(200);
    quiesce();

    $display("Checked %0d responses: %0d ok, %0d with no eligible core, %0d invalid,",
             sb.responses, sb.tally[lla_pkg::ST_OK], sb.tally[lla_pkg::ST_NONE],
             sb.tally[lla_pkg::ST_INVALID]);
    $display("%0d underflow; cores ranged from none online to all online, master in and out.",
             sb.tally[lla_pkg::ST_UNDERFLOW]);
    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lla_pkg.sv
rtl/lla_load_bank.sv
rtl/lla_cmp_unit.sv
rtl/least_loaded_core_allocator.sv
tb/sv/tb_top.sv
